/* rtl/core/osp_pkg.sv */
// osp_pkg: shared constants for the subsatellite point pipeline.
// CORDIC arctangent table, gain constant and Earth rotation factor.
// No dependencies.
package osp_pkg;

    localparam int TAB_LEN = 24;

    typedef logic [31:0] phase_t;

    localparam phase_t HALF_TURN = 32'h8000_0000;
    localparam logic [30:0] GAIN_Q30 = 31'h26DD3B6A;
    localparam logic [20:0] ROT_Q44 = 21'd2031905;

    localparam phase_t ATAN_TAB [0:TAB_LEN-1] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

endpackage

/* rtl/core/osp_sincos.sv */
// osp_sincos: pipelined CORDIC in rotation mode, phase in, Q30 cos/sin out.
// One stage per iteration, between an input register and an output register.
// Depends on osp_pkg.
module osp_sincos
    import osp_pkg::*;
#(
    parameter int NS = 16
) (
    input  logic               clk,
    input  phase_t             phase,
    output logic signed [33:0] cos_q,
    output logic signed [33:0] sin_q
);

    logic signed [33:0] x_reg [0:NS];
    logic signed [33:0] y_reg [0:NS];
    logic signed [32:0] z_reg [0:NS];
    logic               f_reg [0:NS];
    logic               flip;
    phase_t             phf;

    // second and third quadrants are turned by a half turn
    assign flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
    assign phf  = flip ? phase + HALF_TURN : phase;

    always_ff @(posedge clk)
    begin
        x_reg[0] <= $signed({3'b000, GAIN_Q30});
        y_reg[0] <= '0;
        z_reg[0] <= $signed({phf[31], phf});
        f_reg[0] <= flip;
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic signed [33:0] dx, dy;
        logic signed [32:0] at;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        assign at = $signed({1'b0, ATAN_TAB[i]});
        always_ff @(posedge clk)
        begin
            if (!z_reg[i][32])
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                z_reg[i+1] <= z_reg[i] - at;
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                z_reg[i+1] <= z_reg[i] + at;
            end
            f_reg[i+1] <= f_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        cos_q <= f_reg[NS] ? -x_reg[NS] : x_reg[NS];
        sin_q <= f_reg[NS] ? -y_reg[NS] : y_reg[NS];
    end

endmodule

/* rtl/core/osp_vector.sv */
// osp_vector: pipelined CORDIC in vectoring mode, (x, y) in, phase and
// gained magnitude out. Depends on osp_pkg.
module osp_vector
    import osp_pkg::*;
#(
    parameter int W  = 36,
    parameter int NS = 16
) (
    input  logic                 clk,
    input  logic signed [W-1:0]  x_in,
    input  logic signed [W-1:0]  y_in,
    output phase_t               angle,
    output logic signed [W+1:0]  mag
);

    logic signed [W+1:0] x_reg [0:NS];
    logic signed [W+1:0] y_reg [0:NS];
    phase_t              a_reg [0:NS];
    logic                zr_reg [0:NS];

    always_ff @(posedge clk)
    begin
        zr_reg[0] <= (x_in == '0) && (y_in == '0);
        if (x_in[W-1])
        begin
            x_reg[0] <= -(W+2)'(x_in);
            y_reg[0] <= -(W+2)'(y_in);
            a_reg[0] <= HALF_TURN;
        end
        else
        begin
            x_reg[0] <= (W+2)'(x_in);
            y_reg[0] <= (W+2)'(y_in);
            a_reg[0] <= '0;
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_stage
        logic signed [W+1:0] dx, dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (!y_reg[i][W+1])
            begin
                x_reg[i+1] <= x_reg[i] + dx;
                y_reg[i+1] <= y_reg[i] - dy;
                a_reg[i+1] <= a_reg[i] + ATAN_TAB[i];
            end
            else
            begin
                x_reg[i+1] <= x_reg[i] - dx;
                y_reg[i+1] <= y_reg[i] + dy;
                a_reg[i+1] <= a_reg[i] - ATAN_TAB[i];
            end
            zr_reg[i+1] <= zr_reg[i];
        end
    end

    // zero vector gives angle and magnitude zero
    assign angle = zr_reg[NS] ? '0 : a_reg[NS];
    assign mag   = zr_reg[NS] ? '0 : x_reg[NS];

endmodule

/* rtl/core/osp_isqrt.sv */
// osp_isqrt: pipelined digit-by-digit square root of a * 2^32, one root
// bit per stage, 24 stages. Passes a along. No package dependency.
module osp_isqrt (
    input  logic        clk,
    input  logic [15:0] a_in,
    output logic [23:0] root,
    output logic [15:0] a_out
);

    localparam int STEPS = 24;

    logic [26:0] rem_reg [0:STEPS];
    logic [23:0] q_reg   [0:STEPS];
    logic [15:0] a_reg   [0:STEPS];

    assign rem_reg[0] = '0;
    assign q_reg[0]   = '0;
    assign a_reg[0]   = a_in;

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [1:0]  pair;
        logic [26:0] cur, trial;
        // radicand bits come from a in the first eight steps, then zeros
        if (k < 8) begin : g_hi
            assign pair = a_reg[k][15-2*k -: 2];
        end else begin : g_lo
            assign pair = 2'b00;
        end
        assign cur   = {rem_reg[k][24:0], pair};
        assign trial = {1'b0, q_reg[k], 2'b01};
        always_ff @(posedge clk)
        begin
            if (cur >= trial)
            begin
                rem_reg[k+1] <= cur - trial;
                q_reg[k+1]   <= {q_reg[k][22:0], 1'b1};
            end
            else
            begin
                rem_reg[k+1] <= cur;
                q_reg[k+1]   <= {q_reg[k][22:0], 1'b0};
            end
            a_reg[k+1] <= a_reg[k];
        end
    end

    assign root  = q_reg[STEPS];
    assign a_out = a_reg[STEPS];

endmodule

/* rtl/core/osp_rotfac.sv */
// osp_rotfac: Earth rotation angle since node crossing, u * a^1.5 * K.
// Square root pipeline, then registers for a*s, the constant product halves, their sum and u times the sum.
// Depends on osp_pkg and osp_isqrt.
module osp_rotfac
    import osp_pkg::*;
#(
    parameter int AB = 16
) (
    input  logic          clk,
    input  logic [AB-1:0] u,
    input  logic [15:0]   a,
    output phase_t        delta
);

    localparam int UDLY = 27;

    logic [23:0]   s;
    logic [15:0]   a_d;
    logic [39:0]   as_reg;
    logic [40:0]   hi_reg, lo_reg;
    logic [32:0]   kq_reg;
    logic [60:0]   kq_sum;
    logic [AB+32:0] uk;
    logic [AB-1:0] u_reg [0:UDLY];

    osp_isqrt u_sqrt (
        .clk   (clk),
        .a_in  (a),
        .root  (s),
        .a_out (a_d)
    );

    assign u_reg[0] = u;
    for (genvar k = 0; k < UDLY; k++) begin : g_udly
        always_ff @(posedge clk)
        begin
            u_reg[k+1] <= u_reg[k];
        end
    end

    // a*s is 40 bits, split in two halves for the constant product
    assign kq_sum = {hi_reg, 20'b0} + 61'(lo_reg);
    assign uk     = u_reg[UDLY] * kq_reg;

    always_ff @(posedge clk)
    begin
        as_reg <= a_d * s;
        hi_reg <= as_reg[39:20] * ROT_Q44;
        lo_reg <= as_reg[19:0] * ROT_Q44;
        kq_reg <= kq_sum[60:28];
        delta  <= uk[AB+31:AB];
    end

endmodule

/* rtl/core/orbit_subsatellite_point.sv */
// orbit_subsatellite_point: ground latitude/longitude of a circular orbit.
// Done follows the start transfer through a valid shift register; NS = min(CORDIC_STAGES, 24),
// and the path runs through three CORDIC pipelines in series. One item per cycle; busy stays low.
// Reset clears the valid line only; no result appears until a start is taken.
// Depends on osp_pkg, osp_sincos, osp_vector, osp_rotfac.
module orbit_subsatellite_point
    import osp_pkg::*;
#(
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ANGLE_BITS-1:0]        node_longitude,
    input  logic [ANGLE_BITS-1:0]        arg_latitude,
    input  logic [ANGLE_BITS-1:0]        inclination,
    input  logic [15:0]                  semi_major_km,
    output logic                         done,
    output logic signed [ANGLE_BITS-1:0] latitude,
    output logic signed [ANGLE_BITS-1:0] longitude
);

    localparam int NS    = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
    localparam int SH    = 32 - ANGLE_BITS;
    localparam int LAT   = 3 * NS + 7;
    localparam int LDLY  = NS + 2;
    localparam int DDLY  = 3 * NS - 21;
    localparam int ZDLY  = NS + 2;
    localparam phase_t HSTEP = phase_t'(1) << (31 - ANGLE_BITS);
    localparam logic signed [ANGLE_BITS-1:0] QUARTER =
        ANGLE_BITS'(1) << (ANGLE_BITS - 2);

    logic signed [33:0] cl, sl, cu, su, ci, si;
    logic signed [67:0] m_cucl, m_cusl, m_cisl, m_cicl, m_susi;
    logic signed [35:0] p_cucl_reg, p_cusl_reg, p_cisl_reg, p_cicl_reg, p_z_reg;
    logic signed [33:0] su_reg;
    logic signed [69:0] m_a, m_b;
    logic signed [35:0] x_reg, y_reg;
    logic signed [35:0] z_reg [0:ZDLY];
    phase_t             lon_ang, lat_ang;
    logic signed [37:0] mag1, mag2;
    logic signed [69:0] m_r;
    logic signed [35:0] r_reg;
    phase_t             delta;
    phase_t             lon_d [0:LDLY];
    phase_t             del_d [0:DDLY];
    logic [LAT-1:0]     vld_reg;
    phase_t             lon_ph, lat_r, lon_r;
    logic signed [ANGLE_BITS-1:0] lat_b, lat_c;

    assign busy = 1'b0;

    osp_sincos #(.NS(NS)) u_sc_node (
        .clk(clk), .phase(phase_t'(node_longitude) << SH), .cos_q(cl), .sin_q(sl));
    osp_sincos #(.NS(NS)) u_sc_arg (
        .clk(clk), .phase(phase_t'(arg_latitude) << SH), .cos_q(cu), .sin_q(su));
    osp_sincos #(.NS(NS)) u_sc_inc (
        .clk(clk), .phase(phase_t'(inclination) << SH), .cos_q(ci), .sin_q(si));

    osp_rotfac #(.AB(ANGLE_BITS)) u_rot (
        .clk(clk), .u(arg_latitude), .a(semi_major_km), .delta(delta));

    // rotate the orbit-plane unit vector into Earth axes
    assign m_cucl = cu * cl;
    assign m_cusl = cu * sl;
    assign m_cisl = ci * sl;
    assign m_cicl = ci * cl;
    assign m_susi = su * si;
    assign m_a    = su_reg * p_cisl_reg;
    assign m_b    = su_reg * p_cicl_reg;

    always_ff @(posedge clk)
    begin
        p_cucl_reg <= m_cucl[65:30];
        p_cusl_reg <= m_cusl[65:30];
        p_cisl_reg <= m_cisl[65:30];
        p_cicl_reg <= m_cicl[65:30];
        p_z_reg    <= m_susi[65:30];
        su_reg     <= su;
        x_reg      <= p_cucl_reg - m_a[65:30];
        y_reg      <= p_cusl_reg + m_b[65:30];
        z_reg[0]   <= p_z_reg;
    end

    for (genvar k = 0; k < ZDLY; k++) begin : g_zdly
        always_ff @(posedge clk)
        begin
            z_reg[k+1] <= z_reg[k];
        end
    end

    osp_vector #(.W(36), .NS(NS)) u_vec_lon (
        .clk(clk), .x_in(x_reg), .y_in(y_reg), .angle(lon_ang), .mag(mag1));

    // horizontal radius: remove the vectoring gain
    assign m_r = mag1 * $signed({1'b0, GAIN_Q30});
    always_ff @(posedge clk)
    begin
        r_reg <= m_r[65:30];
    end

    osp_vector #(.W(36), .NS(NS)) u_vec_lat (
        .clk(clk), .x_in(r_reg), .y_in(z_reg[ZDLY]), .angle(lat_ang), .mag(mag2));

    assign lon_d[0] = lon_ang;
    for (genvar k = 0; k < LDLY; k++) begin : g_ldly
        always_ff @(posedge clk)
        begin
            lon_d[k+1] <= lon_d[k];
        end
    end

    assign del_d[0] = delta;
    for (genvar k = 0; k < DDLY; k++) begin : g_ddly
        always_ff @(posedge clk)
        begin
            del_d[k+1] <= del_d[k];
        end
    end

    assign lon_ph = lon_d[LDLY] - del_d[DDLY];
    assign lat_r  = lat_ang + HSTEP;
    assign lon_r  = lon_ph + HSTEP;
    assign lat_b  = $signed(lat_r[31:SH]);

    always_comb
    begin
        lat_c = lat_b;
        if (lat_b > QUARTER)
            lat_c = QUARTER;
        if (lat_b < -QUARTER)
            lat_c = -QUARTER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            done    <= 1'b0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start};
            done    <= vld_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        latitude  <= lat_c;
        longitude <= $signed(lon_r[31:SH]);
    end

    // the pipeline never refuses a transfer
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT + 1))
        else $error("done without matching start");

    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (latitude <= QUARTER) && (latitude >= -QUARTER))
        else $error("latitude out of range");

endmodule
